@@ src/far_pkg.sv @@
// Shared types and constants for the fraction arithmetic and reduction block.
package far_pkg;

    // Fixed widths of the result fields
    localparam int RES_NUM_W = 33;
    localparam int RES_DEN_W = 31;

    // Operation codes carried by an input item
    typedef enum logic [2:0] {
        OP_ADD      = 3'd0,
        OP_ABS_DIFF = 3'd1,
        OP_MUL      = 3'd2,
        OP_DIV      = 3'd3,
        OP_CMP      = 3'd4
    } op_t;

    // Three-way compare codes
    typedef enum logic [1:0] {
        CMP_LT = 2'd0,
        CMP_EQ = 2'd1,
        CMP_GT = 2'd2
    } cmp_t;

    // Sequencer states, one-hot
    typedef enum logic [8:0] {
        S_IDLE  = 9'b0_0000_0001,
        S_MUL0  = 9'b0_0000_0010,
        S_MUL1  = 9'b0_0000_0100,
        S_MUL2  = 9'b0_0000_1000,
        S_SETUP = 9'b0_0001_0000,
        S_GCD   = 9'b0_0010_0000,
        S_DIVN  = 9'b0_0100_0000,
        S_DIVD  = 9'b0_1000_0000,
        S_DONE  = 9'b1_0000_0000
    } state_t;

endpackage

@@ src/far_sub.sv @@
// Shared unsigned subtract and compare unit used by the GCD and divide steps.
module far_sub #(
    parameter int WIDTH = 32
) (
    input  logic [WIDTH-1:0] a,
    input  logic [WIDTH-1:0] b,
    output logic [WIDTH-1:0] diff,
    output logic             borrow
);

    logic [WIDTH:0] full;

    // Subtract with one guard bit; the guard bit is the borrow (a < b)
    assign full   = {1'b0, a} - {1'b0, b};
    assign diff   = full[WIDTH-1:0];
    assign borrow = full[WIDTH];

endmodule

@@ src/fraction_arith_reduce.sv @@
// Top level: signed fraction add, absolute difference, multiply, divide and compare with reduction.
//
// One item at a time: after an item is accepted in_stall stays high until its result is
// loaded into the output register, which then waits for the consumer while the next item
// is taken. Cross products come from one shared signed multiplier in S_MUL0, S_MUL1 and,
// for add and difference, S_MUL2. The reduced result uses a binary GCD (shift, swap or
// subtract, one step a cycle; every swap leads to a subtract, every subtract to a shift or
// the end) and then two restoring divisions, numerator then denominator, all on one shared
// subtractor. Compare, division by zero and zero results skip the GCD and the divisions.
module fraction_arith_reduce #(
    parameter int FIELD_WIDTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [2:0]                          op,
    input  logic signed [FIELD_WIDTH-1:0]       num_a,
    input  logic [FIELD_WIDTH-2:0]              den_a,
    input  logic signed [FIELD_WIDTH-1:0]       num_b,
    input  logic [FIELD_WIDTH-2:0]              den_b,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [far_pkg::RES_NUM_W-1:0] res_num,
    output logic [far_pkg::RES_DEN_W-1:0]       res_den,
    output logic [1:0]                          cmp_code,
    output logic                                div_zero
);

    localparam int W  = FIELD_WIDTH;
    localparam int PW = 2 * W;            // signed product / sum width
    localparam int MW = 2 * W - 1;        // magnitude width
    localparam int CW = $clog2(MW + 1);   // step counter and shift count width
    localparam int XN = (MW + 1 > far_pkg::RES_NUM_W) ? MW + 1 : far_pkg::RES_NUM_W;
    localparam int XD = (MW > far_pkg::RES_DEN_W) ? MW : far_pkg::RES_DEN_W;

    far_pkg::state_t state_reg, state_next;

    // Operand and working registers
    logic [2:0]              op_reg;
    logic signed [W-1:0]     a_reg, c_reg;
    logic [W-2:0]            b_reg, d_reg;
    logic signed [PW-1:0]    p1_reg, p2_reg;
    logic                    neg_reg;
    logic [MW-1:0]           mag_reg, den_reg;
    logic [MW-1:0]           u_reg, v_reg, g_reg;
    logic [CW-1:0]           k_reg, cnt_reg;
    logic [MW-1:0]           x_reg, rem_reg, qn_reg;

    // Staged result and output registers
    logic signed [far_pkg::RES_NUM_W-1:0] st_num_reg, res_num_reg;
    logic [far_pkg::RES_DEN_W-1:0]        st_den_reg, res_den_reg;
    logic [1:0]                           st_cmp_reg, cmp_reg;
    logic                                 st_dz_reg, dz_reg;
    logic                                 out_valid_reg;

    logic in_accept, out_load;

    assign in_stall  = (state_reg != far_pkg::S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_load  = (state_reg == far_pkg::S_DONE) && (!out_valid_reg || !out_stall);

    // Shared multiplier: select operands by state and operation
    logic [W-1:0]            c_abs;
    logic signed [W:0]       mul_x, mul_y;
    logic signed [2*W+1:0]   mul_full;
    logic signed [PW-1:0]    prod;

    assign c_abs = c_reg[W-1] ? (W'(0) - W'(c_reg)) : W'(c_reg);

    always_comb
    begin
        mul_x = {a_reg[W-1], a_reg};
        mul_y = {2'b00, d_reg};
        case (state_reg)
            far_pkg::S_MUL0:
            begin
                if (op_reg == far_pkg::OP_MUL)
                begin
                    mul_y = {c_reg[W-1], c_reg};
                end
            end
            far_pkg::S_MUL1:
            begin
                if (op_reg == far_pkg::OP_MUL)
                begin
                    mul_x = {2'b00, b_reg};
                    mul_y = {2'b00, d_reg};
                end
                else if (op_reg == far_pkg::OP_DIV)
                begin
                    mul_x = {2'b00, b_reg};
                    mul_y = {1'b0, c_abs};
                end
                else
                begin
                    mul_x = {c_reg[W-1], c_reg};
                    mul_y = {2'b00, b_reg};
                end
            end
            far_pkg::S_MUL2:
            begin
                mul_x = {2'b00, b_reg};
                mul_y = {2'b00, d_reg};
            end
            default:
            begin
                mul_x = {a_reg[W-1], a_reg};
                mul_y = {2'b00, d_reg};
            end
        endcase
    end

    assign mul_full = mul_x * mul_y;
    assign prod     = mul_full[PW-1:0];

    // Shared subtractor: GCD compare/subtract or one divide step
    logic [MW:0] sub_a, sub_b, sub_diff;
    logic        sub_borrow;
    logic [MW:0] trial;

    assign trial = {rem_reg, x_reg[MW-1]};

    always_comb
    begin
        if (state_reg == far_pkg::S_GCD)
        begin
            sub_a = {1'b0, u_reg};
            sub_b = {1'b0, v_reg};
        end
        else
        begin
            sub_a = trial;
            sub_b = {1'b0, g_reg};
        end
    end

    far_sub #(
        .WIDTH (MW + 1)
    ) u_sub (
        .a      (sub_a),
        .b      (sub_b),
        .diff   (sub_diff),
        .borrow (sub_borrow)
    );

    // Divide step results
    logic [MW-1:0] rem_step, x_step;

    assign rem_step = sub_borrow ? trial[MW-1:0] : sub_diff[MW-1:0];
    assign x_step   = {x_reg[MW-2:0], !sub_borrow};

    // Setup values: sign and magnitude of the numerator
    logic          setup_neg;
    logic [PW-1:0] p1_abs;
    logic [MW-1:0] setup_mag;

    assign p1_abs    = p1_reg[PW-1] ? (PW'(0) - PW'(p1_reg)) : PW'(p1_reg);
    assign setup_mag = p1_abs[MW-1:0];

    always_comb
    begin
        case (op_reg)
            far_pkg::OP_ABS_DIFF: setup_neg = 1'b0;
            far_pkg::OP_DIV:      setup_neg = p1_reg[PW-1] ^ c_reg[W-1];
            default:              setup_neg = p1_reg[PW-1];
        endcase
    end

    // Final result formatting from reduced magnitudes
    logic [XN-1:0] num_ext, num_wide;
    logic [XD-1:0] den_wide;

    assign num_ext  = XN'(qn_reg);
    assign num_wide = neg_reg ? (XN'(0) - num_ext) : num_ext;
    assign den_wide = XD'(x_step);

    logic gcd_done;
    assign gcd_done = (u_reg == '0) || (v_reg == '0);

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            far_pkg::S_IDLE:
            begin
                if (in_accept)
                begin
                    if (op == far_pkg::OP_ADD || op == far_pkg::OP_ABS_DIFF
                        || op == far_pkg::OP_MUL || op == far_pkg::OP_CMP
                        || (op == far_pkg::OP_DIV && num_b != '0))
                    begin
                        state_next = far_pkg::S_MUL0;
                    end
                    else
                    begin
                        state_next = far_pkg::S_DONE;
                    end
                end
            end
            far_pkg::S_MUL0:
            begin
                state_next = far_pkg::S_MUL1;
            end
            far_pkg::S_MUL1:
            begin
                if (op_reg == far_pkg::OP_ADD || op_reg == far_pkg::OP_ABS_DIFF)
                begin
                    state_next = far_pkg::S_MUL2;
                end
                else
                begin
                    state_next = far_pkg::S_SETUP;
                end
            end
            far_pkg::S_MUL2:
            begin
                state_next = far_pkg::S_SETUP;
            end
            far_pkg::S_SETUP:
            begin
                if (op_reg == far_pkg::OP_CMP || setup_mag == '0)
                begin
                    state_next = far_pkg::S_DONE;
                end
                else
                begin
                    state_next = far_pkg::S_GCD;
                end
            end
            far_pkg::S_GCD:
            begin
                if (gcd_done)
                begin
                    state_next = far_pkg::S_DIVN;
                end
            end
            far_pkg::S_DIVN:
            begin
                if (cnt_reg == CW'(MW - 1))
                begin
                    state_next = far_pkg::S_DIVD;
                end
            end
            far_pkg::S_DIVD:
            begin
                if (cnt_reg == CW'(MW - 1))
                begin
                    state_next = far_pkg::S_DONE;
                end
            end
            far_pkg::S_DONE:
            begin
                if (out_load)
                begin
                    state_next = far_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = far_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= far_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            far_pkg::S_IDLE:
            begin
                if (in_accept)
                begin
                    op_reg     <= op;
                    a_reg      <= num_a;
                    b_reg      <= den_a;
                    c_reg      <= num_b;
                    d_reg      <= den_b;
                    st_num_reg <= '0;
                    st_den_reg <= '0;
                    st_cmp_reg <= far_pkg::CMP_LT;
                    st_dz_reg  <= (op == far_pkg::OP_DIV) && (num_b == '0);
                end
            end
            far_pkg::S_MUL0:
            begin
                p1_reg <= prod;
            end
            far_pkg::S_MUL1:
            begin
                p2_reg <= prod;
            end
            far_pkg::S_MUL2:
            begin
                // Combine cross products and load the common denominator
                if (op_reg == far_pkg::OP_ADD)
                begin
                    p1_reg <= p1_reg + p2_reg;
                end
                else
                begin
                    p1_reg <= p1_reg - p2_reg;
                end
                p2_reg <= prod;
            end
            far_pkg::S_SETUP:
            begin
                if (op_reg == far_pkg::OP_CMP)
                begin
                    if (p1_reg < p2_reg)
                    begin
                        st_cmp_reg <= far_pkg::CMP_LT;
                    end
                    else if (p1_reg == p2_reg)
                    begin
                        st_cmp_reg <= far_pkg::CMP_EQ;
                    end
                    else
                    begin
                        st_cmp_reg <= far_pkg::CMP_GT;
                    end
                end
                else if (setup_mag == '0)
                begin
                    st_den_reg <= far_pkg::RES_DEN_W'(1);
                end
                else
                begin
                    neg_reg <= setup_neg;
                    mag_reg <= setup_mag;
                    den_reg <= p2_reg[MW-1:0];
                    u_reg   <= setup_mag;
                    v_reg   <= p2_reg[MW-1:0];
                    k_reg   <= '0;
                end
            end
            far_pkg::S_GCD:
            begin
                // One binary GCD step: shift out twos, swap, or subtract
                if (gcd_done)
                begin
                    g_reg   <= (u_reg | v_reg) << k_reg;
                    x_reg   <= mag_reg;
                    rem_reg <= '0;
                    cnt_reg <= '0;
                end
                else if (!u_reg[0] && !v_reg[0])
                begin
                    u_reg <= u_reg >> 1;
                    v_reg <= v_reg >> 1;
                    k_reg <= k_reg + CW'(1);
                end
                else if (!u_reg[0])
                begin
                    u_reg <= u_reg >> 1;
                end
                else if (!v_reg[0])
                begin
                    v_reg <= v_reg >> 1;
                end
                else if (sub_borrow)
                begin
                    u_reg <= v_reg;
                    v_reg <= u_reg;
                end
                else
                begin
                    u_reg <= sub_diff[MW-1:0];
                end
            end
            far_pkg::S_DIVN:
            begin
                // Restoring divide of the numerator magnitude by the GCD
                if (cnt_reg == CW'(MW - 1))
                begin
                    qn_reg  <= x_step;
                    x_reg   <= den_reg;
                    rem_reg <= '0;
                    cnt_reg <= '0;
                end
                else
                begin
                    x_reg   <= x_step;
                    rem_reg <= rem_step;
                    cnt_reg <= cnt_reg + CW'(1);
                end
            end
            far_pkg::S_DIVD:
            begin
                // Divide the denominator, then stage the signed result
                x_reg   <= x_step;
                rem_reg <= rem_step;
                cnt_reg <= cnt_reg + CW'(1);
                if (cnt_reg == CW'(MW - 1))
                begin
                    st_num_reg <= num_wide[far_pkg::RES_NUM_W-1:0];
                    st_den_reg <= den_wide[far_pkg::RES_DEN_W-1:0];
                end
            end
            far_pkg::S_DONE:
            begin
                if (out_load)
                begin
                    res_num_reg <= st_num_reg;
                    res_den_reg <= st_den_reg;
                    cmp_reg     <= st_cmp_reg;
                    dz_reg      <= st_dz_reg;
                end
            end
            default:
            begin
                op_reg <= op_reg;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign res_num   = res_num_reg;
    assign res_den   = res_den_reg;
    assign cmp_code  = cmp_reg;
    assign div_zero  = dz_reg;

endmodule

@@ src/far_check.sv @@
// Port-level checker for the fraction arithmetic block, bound to the top level.
module far_check #(
    parameter int FIELD_WIDTH = 16
) (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_stall,
    input logic [2:0]                          op,
    input logic signed [FIELD_WIDTH-1:0]       num_a,
    input logic [FIELD_WIDTH-2:0]              den_a,
    input logic signed [FIELD_WIDTH-1:0]       num_b,
    input logic [FIELD_WIDTH-2:0]              den_b,
    input logic                                out_valid,
    input logic                                out_stall,
    input logic signed [far_pkg::RES_NUM_W-1:0] res_num,
    input logic [far_pkg::RES_DEN_W-1:0]       res_den,
    input logic [1:0]                          cmp_code,
    input logic                                div_zero
);

    // An accepted item keeps the block busy for at least the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken again right after an item was accepted");

    // A division by zero carries no fraction and no compare code
    a_div_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && div_zero) |-> (res_num == '0 && res_den == '0
                                     && cmp_code == far_pkg::CMP_LT))
        else $error("division by zero item with nonzero fields");

    // A compare result of equal or greater has zero fraction fields and no division by zero flag
    a_cmp_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && cmp_code != far_pkg::CMP_LT)
        |-> (res_num == '0 && res_den == '0 && !div_zero
             && (cmp_code == far_pkg::CMP_EQ || cmp_code == far_pkg::CMP_GT)))
        else $error("compare item with bad fields");

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(res_num)
                                      && $stable(res_den) && $stable(cmp_code)
                                      && $stable(div_zero)))
        else $error("stalled result item changed");

endmodule

bind fraction_arith_reduce far_check #(.FIELD_WIDTH(FIELD_WIDTH)) u_far_check (.*);
